// ===== hw/rtl/rfhw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhw_pkg
// Shared types and constants of the RGB fade and hue wheel driver.
// ----------------------------------------------------------------------------
package rfhw_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH       = 2;

   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_SET   = 2'd1;
   localparam logic [1:0] REQ_FADE  = 2'd2;
   localparam logic [1:0] REQ_WHEEL = 2'd3;

   localparam logic [1:0] MODE_HOLD  = 2'd0;
   localparam logic [1:0] MODE_FADE  = 2'd1;
   localparam logic [1:0] MODE_WHEEL = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE         = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHEEL_INTERVAL = 2'd1;

   localparam logic        ENABLE_RESET   = 1'b1;
   localparam logic [15:0] INTERVAL_RESET = 16'd100;

   localparam logic [10:0] WHEEL_TOP  = 11'd1530;
   localparam logic [10:0] WHEEL_SEG1 = 11'd255;
   localparam logic [10:0] WHEEL_SEG2 = 11'd510;
   localparam logic [10:0] WHEEL_SEG3 = 11'd765;
   localparam logic [10:0] WHEEL_SEG4 = 11'd1020;
   localparam logic [10:0] WHEEL_SEG5 = 11'd1275;
   localparam logic [7:0]  FULL_ON    = 8'hff;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_SET,
      OP_FADE,
      OP_WHEEL
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        snap;
      logic [31:0] time_ms;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] fade_ticks;
   } item_type;

   typedef struct packed {
      logic        enable;
      logic [15:0] wheel_interval_ms;
   } csr_type;

endpackage

// ===== hw/rtl/rgb_fade_and_hue_wheel_driver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_fade_and_hue_wheel_driver
// RGB colour engine with hold, linear fade and hue wheel modes.
// ----------------------------------------------------------------------------
// Each request beat returns one response beat carrying the colour and mode as
// they stood before the request acted. A two-entry queue decouples intake from
// the back end. A fade with a nonzero period computes the three per-tick steps
// in turn on one shared restoring divider, one quotient bit per cycle, and the
// back end takes no new request until all three steps are done. Configuration
// writes are never stalled.
// ----------------------------------------------------------------------------
module rgb_fade_and_hue_wheel_driver #(
   parameter int FRAC_BITS = rfhw_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // time_ms[31:0], red_in[39:32], green_in[47:40], blue_in[55:48],
   // fade_ticks[71:56]
   input  logic [rfhw_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_type[1:0]
   input  logic [rfhw_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // red_out[7:0], green_out[15:8], blue_out[23:16], mode_out[25:24]
   output logic [rfhw_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rfhw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rfhw_pkg::CSR_DATA_W-1:0]      csr_data
);

   logic                enable_ff;
   logic [15:0]         interval_ff;
   rfhw_pkg::csr_type   csr;
   rfhw_pkg::item_type  item;
   logic                item_valid;
   logic                item_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= rfhw_pkg::ENABLE_RESET;
         interval_ff <= rfhw_pkg::INTERVAL_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == rfhw_pkg::CSR_ENABLE) begin
            enable_ff <= csr_data[0];
         end else if (csr_index == rfhw_pkg::CSR_WHEEL_INTERVAL) begin
            interval_ff <= csr_data;
         end
      end
   end

   assign csr.enable            = enable_ff;
   assign csr.wheel_interval_ms = interval_ff;

   rfhw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   rfhw_engine #(
      .FRAC_BITS (FRAC_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== hw/rtl/rfhw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhw_front
// Request intake: decode each beat into an operation and queue it.
// ----------------------------------------------------------------------------
module rfhw_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // time_ms[31:0], red_in[39:32], green_in[47:40], blue_in[55:48],
   // fade_ticks[71:56]
   input  logic [rfhw_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type[1:0]
   input  logic [rfhw_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                item_valid,
   output rfhw_pkg::item_type                  item,
   input  logic                                item_pop
);

   localparam int DEPTH = rfhw_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rfhw_pkg::item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [CNT_W-1:0]       count_ff;
   rfhw_pkg::item_type     item_in;
   logic                   push;

   always_comb begin
      item_in            = '0;
      item_in.time_ms    = req_tdata[31:0];
      item_in.red        = req_tdata[39:32];
      item_in.green      = req_tdata[47:40];
      item_in.blue       = req_tdata[55:48];
      item_in.fade_ticks = req_tdata[71:56];
      item_in.snap       = (req_tdata[71:56] == 16'd0);
      unique case (req_tuser)
         rfhw_pkg::REQ_TICK:  item_in.op = rfhw_pkg::OP_TICK;
         rfhw_pkg::REQ_SET:   item_in.op = rfhw_pkg::OP_SET;
         rfhw_pkg::REQ_FADE:  item_in.op = rfhw_pkg::OP_FADE;
         rfhw_pkg::REQ_WHEEL: item_in.op = rfhw_pkg::OP_WHEEL;
         default:             item_in.op = rfhw_pkg::OP_TICK;
      endcase
   end

   assign req_tready = (count_ff != CNT_W'(DEPTH));
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != '0);
   assign item       = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (item_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !item_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (item_pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> count_ff != '0)
      else $error("queue popped while empty");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !item_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill count lost a beat");

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_W'(DEPTH)) |-> !req_tready)
      else $error("queue accepts beat while full");

endmodule

// ===== hw/rtl/rfhw_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhw_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module rfhw_div #(
   parameter int DW = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [15:0]   divisor,
   output logic          busy,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CNT_W = $clog2(DW + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [DW-1:0]     quot_ff;
   logic [15:0]       rem_ff;
   logic [15:0]       divisor_ff;
   logic [16:0]       rem_shift;
   logic              fits;

   assign rem_shift = {rem_ff, quot_ff[DW-1]};
   assign fits      = (rem_shift >= {1'b0, divisor_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == CNT_W'(DW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff    <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff  <= 16'(rem_shift - {1'b0, divisor_ff});
            quot_ff <= {quot_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift[15:0];
            quot_ff <= {quot_ff[DW-2:0], 1'b0};
         end
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quot_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a run");

   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("divider busy and done together");

endmodule

// ===== hw/rtl/rfhw_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhw_engine
// Back end: report the driven colour, then run tick, set, fade or wheel.
// ----------------------------------------------------------------------------
module rfhw_engine #(
   parameter int FRAC_BITS = rfhw_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rfhw_pkg::csr_type                csr,
   input  logic                             item_valid,
   input  rfhw_pkg::item_type               item,
   output logic                             item_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rfhw_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int LW = 8 + FRAC_BITS;
   localparam int SW = 9 + FRAC_BITS;
   localparam int VW = 10 + FRAC_BITS;
   localparam logic [LW-1:0] LEVEL_MAX = '1;
   localparam logic [LW-1:0] ONE_FIX   = LW'(1) << FRAC_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV_START,
      S_DIV_WAIT
   } state_type;

   state_type              state_ff;
   logic [LW-1:0]          level_ff  [3];
   logic [7:0]             target_ff [3];
   logic signed [SW-1:0]   step_ff   [3];
   logic [1:0]             mode_ff;
   logic [10:0]            wheel_pos_ff;
   logic [31:0]            last_tick_ff;
   logic [31:0]            last_wheel_ff;
   logic [15:0]            period_ff;
   logic [1:0]             ch_ff;
   logic                   div_start_ff;
   logic                   rsp_valid_ff;
   logic [rfhw_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [LW-1:0]          level_tick_in [3];
   logic signed [SW-1:0]   step_tick_in  [3];
   logic                   steps_zero;
   logic [10:0]            wheel_pos_in;
   logic [23:0]            wheel_rgb;
   logic [31:0]            elapsed;
   logic [LW-1:0]          div_level;
   logic [LW-1:0]          div_goal;
   logic                   div_neg;
   logic [LW-1:0]          div_mag;
   logic                   div_busy;
   logic                   div_done;
   logic [LW-1:0]          div_quot;
   logic signed [SW-1:0]   div_step;
   logic                   pop;

   function automatic logic [23:0] wheel_color(input logic [10:0] pos);
      logic [10:0] p;
      logic [10:0] t;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      p = (pos > rfhw_pkg::WHEEL_TOP) ? rfhw_pkg::WHEEL_TOP : pos;
      r = '0;
      g = '0;
      b = '0;
      t = '0;
      priority if (p <= rfhw_pkg::WHEEL_SEG1) begin
         r = rfhw_pkg::FULL_ON;
         g = p[7:0];
      end else if (p <= rfhw_pkg::WHEEL_SEG2) begin
         t = rfhw_pkg::WHEEL_SEG2 - p;
         r = t[7:0];
         g = rfhw_pkg::FULL_ON;
      end else if (p <= rfhw_pkg::WHEEL_SEG3) begin
         t = p - rfhw_pkg::WHEEL_SEG2;
         g = rfhw_pkg::FULL_ON;
         b = t[7:0];
      end else if (p <= rfhw_pkg::WHEEL_SEG4) begin
         t = rfhw_pkg::WHEEL_SEG4 - p;
         g = t[7:0];
         b = rfhw_pkg::FULL_ON;
      end else if (p <= rfhw_pkg::WHEEL_SEG5) begin
         t = p - rfhw_pkg::WHEEL_SEG4;
         r = t[7:0];
         b = rfhw_pkg::FULL_ON;
      end else begin
         t = rfhw_pkg::WHEEL_TOP - p;
         r = rfhw_pkg::FULL_ON;
         b = t[7:0];
      end
      return {b, g, r};
   endfunction

   always_comb begin
      logic signed [VW-1:0] sum;
      logic [LW-1:0]        v;
      logic [LW-1:0]        goal;
      logic [LW-1:0]        d;
      for (int i = 0; i < 3; i++) begin
         sum = $signed({2'b00, level_ff[i]}) + $signed({step_ff[i][SW-1], step_ff[i]});
         if (sum < 0) begin
            v = '0;
         end else if (sum > $signed({2'b00, LEVEL_MAX})) begin
            v = LEVEL_MAX;
         end else begin
            v = sum[LW-1:0];
         end
         goal = {target_ff[i], {FRAC_BITS{1'b0}}};
         d    = (v >= goal) ? v - goal : goal - v;
         if (d < ONE_FIX) begin
            level_tick_in[i] = goal;
            step_tick_in[i]  = '0;
         end else begin
            level_tick_in[i] = v;
            step_tick_in[i]  = step_ff[i];
         end
      end
   end

   assign steps_zero = (step_tick_in[0] == '0) && (step_tick_in[1] == '0) &&
                       (step_tick_in[2] == '0);

   assign wheel_pos_in = (wheel_pos_ff > rfhw_pkg::WHEEL_TOP) ? '0 : wheel_pos_ff + 1'b1;
   assign wheel_rgb    = wheel_color(wheel_pos_in);
   assign elapsed      = item.time_ms - last_wheel_ff;

   assign div_level = level_ff[ch_ff];
   assign div_goal  = {target_ff[ch_ff], {FRAC_BITS{1'b0}}};
   assign div_neg   = (div_level > div_goal);
   assign div_mag   = div_neg ? div_level - div_goal : div_goal - div_level;
   assign div_step  = div_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

   rfhw_div #(
      .DW (LW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_mag),
      .divisor  (period_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign pop      = (state_ff == S_IDLE) && item_valid && (!rsp_valid_ff || rsp_tready);
   assign item_pop = pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= rfhw_pkg::MODE_HOLD;
         wheel_pos_ff  <= '0;
         last_tick_ff  <= '0;
         last_wheel_ff <= '0;
         ch_ff         <= '0;
         div_start_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         period_ff     <= '0;
         rsp_data_ff   <= '0;
         for (int i = 0; i < 3; i++) begin
            level_ff[i]  <= '0;
            target_ff[i] <= '0;
            step_ff[i]   <= '0;
         end
      end else begin
         div_start_ff <= 1'b0;
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {6'b0, mode_ff, level_ff[2][LW-1 -: 8],
                                   level_ff[1][LW-1 -: 8], level_ff[0][LW-1 -: 8]};
                  unique case (item.op)
                     rfhw_pkg::OP_TICK: begin
                        if (csr.enable) begin
                           if (mode_ff == rfhw_pkg::MODE_FADE &&
                               last_tick_ff != item.time_ms) begin
                              for (int i = 0; i < 3; i++) begin
                                 level_ff[i] <= level_tick_in[i];
                                 step_ff[i]  <= step_tick_in[i];
                              end
                              if (steps_zero) begin
                                 mode_ff <= rfhw_pkg::MODE_HOLD;
                              end
                           end else if (mode_ff == rfhw_pkg::MODE_WHEEL &&
                                        elapsed > {16'd0, csr.wheel_interval_ms}) begin
                              wheel_pos_ff  <= wheel_pos_in;
                              level_ff[0]   <= {wheel_rgb[7:0], {FRAC_BITS{1'b0}}};
                              level_ff[1]   <= {wheel_rgb[15:8], {FRAC_BITS{1'b0}}};
                              level_ff[2]   <= {wheel_rgb[23:16], {FRAC_BITS{1'b0}}};
                              last_wheel_ff <= item.time_ms;
                           end
                        end
                        last_tick_ff <= item.time_ms;
                     end
                     rfhw_pkg::OP_SET: begin
                        level_ff[0] <= {item.red, {FRAC_BITS{1'b0}}};
                        level_ff[1] <= {item.green, {FRAC_BITS{1'b0}}};
                        level_ff[2] <= {item.blue, {FRAC_BITS{1'b0}}};
                        mode_ff     <= rfhw_pkg::MODE_HOLD;
                     end
                     rfhw_pkg::OP_FADE: begin
                        target_ff[0] <= item.red;
                        target_ff[1] <= item.green;
                        target_ff[2] <= item.blue;
                        if (item.snap) begin
                           level_ff[0] <= {item.red, {FRAC_BITS{1'b0}}};
                           level_ff[1] <= {item.green, {FRAC_BITS{1'b0}}};
                           level_ff[2] <= {item.blue, {FRAC_BITS{1'b0}}};
                           for (int i = 0; i < 3; i++) begin
                              step_ff[i] <= '0;
                           end
                           mode_ff <= rfhw_pkg::MODE_HOLD;
                        end else begin
                           period_ff <= item.fade_ticks;
                           ch_ff     <= '0;
                           mode_ff   <= rfhw_pkg::MODE_FADE;
                           state_ff  <= S_DIV_START;
                        end
                     end
                     rfhw_pkg::OP_WHEEL: begin
                        mode_ff <= rfhw_pkg::MODE_WHEEL;
                     end
                     default: begin
                        mode_ff <= mode_ff;
                     end
                  endcase
               end
            end
            S_DIV_START: begin
               div_start_ff <= 1'b1;
               state_ff     <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  step_ff[ch_ff] <= div_step;
                  if (ch_ff == 2'd2) begin
                     state_ff <= S_IDLE;
                  end else begin
                     ch_ff    <= ch_ff + 1'b1;
                     state_ff <= S_DIV_START;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!rsp_valid_ff || rsp_tready))
      else $error("beat taken while result slot is full");

   a_rsp_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pop))
      else $error("result appeared without a request");

   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> state_ff == S_DIV_WAIT)
      else $error("divider running outside the step computation");

   a_fade_mode: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> mode_ff == rfhw_pkg::MODE_FADE)
      else $error("step computation outside fade mode");

endmodule

// ===== bench/tb_rgb_fade_and_hue_wheel_driver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_fade_and_hue_wheel_driver
// Self-checking bench for the RGB fade and hue wheel colour engine.
// ----------------------------------------------------------------------------
// A short table of requests comes first. It covers reset state, set, snap and
// timed fades, same-time ticks, vanishing steps and wheel advances at the edge
// of the interval and at the top of the 32-bit time range.
// Random phases follow under several register settings, the extremes among
// them. Most of their traffic is runs of fade, wheel and set requests with
// ticks, and the rest is random noise. A final sweep drives the hue wheel
// through a full lap.
// A local colour engine predicts every response beat that the table does not
// give directly. Each beat is compared field by field in order of arrival. Both
// sides of the stream stall at random, except in one phase that runs without stalls.
// ----------------------------------------------------------------------------
module tb_rgb_fade_and_hue_wheel_driver;
   import rfhw_pkg::*;

   localparam int          FRAC          = FRAC_BITS_DEFAULT;
   localparam int          LEVEL_W       = 8 + FRAC;
   localparam int          STEP_W        = 9 + FRAC;
   localparam longint      ONE_LEVEL     = longint'(1) << FRAC;
   localparam longint      LEVEL_TOP     = (longint'(256) << FRAC) - 1;
   localparam int          SETTLE_CYCLES = 100;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int          IDLE_PERCENT  = 37;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      op_type      kind;
      logic [31:0] time_ms;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] fade_ticks;
   } led_cmd_t;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [1:0] mode;
   } colour_t;

   typedef struct packed {
      bit       typed;
      led_cmd_t cmd;
      colour_t  want;
   } dir_row_t;

   localparam colour_t NO_COLOUR = '0;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [REQ_USER_W-1:0]  req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // engine shadow state
   logic [LEVEL_W-1:0]       chan_level [3];
   logic [7:0]               chan_goal  [3];
   logic signed [STEP_W-1:0] chan_step  [3];
   logic [1:0]               eng_mode;
   logic [10:0]              hue_pos;
   logic [31:0]              last_tick_ms;
   logic [31:0]              last_wheel_ms;
   logic                     reg_on;
   logic [15:0]              reg_interval;

   colour_t     expected_colours [$];
   bit          steady = 1'b0;
   logic [31:0] clock_ms = '0;
   int          mismatches = 0;
   int          req_beats = 0;
   int          rsp_beats = 0;
   int          settings = 1;
   int unsigned cycle_count = 0;

   dir_row_t directed_rows [25] = '{
      '{1'b1, '{OP_TICK,  32'd0,        8'h00, 8'h00, 8'h00, 16'd0},
            '{8'h00, 8'h00, 8'h00, MODE_HOLD}},
      '{1'b1, '{OP_SET,   32'd0,        8'hff, 8'hff, 8'hff, 16'd0},
            '{8'h00, 8'h00, 8'h00, MODE_HOLD}},
      '{1'b1, '{OP_TICK,  32'd5,        8'h00, 8'h00, 8'h00, 16'd0},
            '{8'hff, 8'hff, 8'hff, MODE_HOLD}},
      '{1'b1, '{OP_SET,   32'd0,        8'h00, 8'h00, 8'h00, 16'd0},
            '{8'hff, 8'hff, 8'hff, MODE_HOLD}},
      '{1'b1, '{OP_FADE,  32'd0,        8'hff, 8'h00, 8'h80, 16'd0},
            '{8'h00, 8'h00, 8'h00, MODE_HOLD}},
      '{1'b1, '{OP_TICK,  32'd6,        8'h00, 8'h00, 8'h00, 16'd0},
            '{8'hff, 8'h00, 8'h80, MODE_HOLD}},
      '{1'b1, '{OP_FADE,  32'd0,        8'h00, 8'hff, 8'hff, 16'd4},
            '{8'hff, 8'h00, 8'h80, MODE_HOLD}},
      '{1'b1, '{OP_TICK,  32'd6,        8'h00, 8'h00, 8'h00, 16'd0},
            '{8'hff, 8'h00, 8'h80, MODE_FADE}},
      '{1'b0, '{OP_TICK,  32'd7,        8'h00, 8'h00, 8'h00, 16'd0}, NO_COLOUR},
      '{1'b0, '{OP_TICK,  32'd8,        8'h00, 8'h00, 8'h00, 16'd0}, NO_COLOUR},
      '{1'b0, '{OP_TICK,  32'd9,        8'h00, 8'h00, 8'h00, 16'd0}, NO_COLOUR},
      '{1'b0, '{OP_TICK,  32'd10,       8'h00, 8'h00, 8'h00, 16'd0}, NO_COLOUR},
      '{1'b0, '{OP_TICK,  32'd11,       8'h00, 8'h00, 8'h00, 16'd0}, NO_COLOUR},
      '{1'b0, '{OP_FADE,  32'hffffffff, 8'h00, 8'hff, 8'hff, 16'hffff}, NO_COLOUR},
      '{1'b0, '{OP_TICK,  32'd12,       8'h00, 8'h00, 8'h00, 16'd0}, NO_COLOUR},
      '{1'b0, '{OP_SET,   32'd0,        8'h03, 8'hc8, 8'h00, 16'd0}, NO_COLOUR},
      '{1'b0, '{OP_FADE,  32'd0,        8'h00, 8'hc9, 8'h01, 16'hffff}, NO_COLOUR},
      '{1'b0, '{OP_TICK,  32'd13,       8'h00, 8'h00, 8'h00, 16'd0}, NO_COLOUR},
      '{1'b0, '{OP_TICK,  32'd14,       8'h00, 8'h00, 8'h00, 16'd0}, NO_COLOUR},
      '{1'b0, '{OP_WHEEL, 32'd0,        8'hff, 8'hff, 8'hff, 16'hffff}, NO_COLOUR},
      '{1'b0, '{OP_TICK,  32'd100,      8'h00, 8'h00, 8'h00, 16'd0}, NO_COLOUR},
      '{1'b0, '{OP_TICK,  32'd101,      8'h00, 8'h00, 8'h00, 16'd0}, NO_COLOUR},
      '{1'b0, '{OP_TICK,  32'hffffffff, 8'hff, 8'hff, 8'hff, 16'hffff}, NO_COLOUR},
      '{1'b0, '{OP_TICK,  32'hffffffff, 8'h00, 8'h00, 8'h00, 16'd0}, NO_COLOUR},
      '{1'b0, '{OP_SET,   32'hffffffff, 8'hff, 8'hff, 8'hff, 16'hffff}, NO_COLOUR}
   };

   rgb_fade_and_hue_wheel_driver #(
      .FRAC_BITS(FRAC)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses pending", $time,
                  expected_colours.size());
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic void load_level(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      chan_level[0] = {r, {FRAC{1'b0}}};
      chan_level[1] = {g, {FRAC{1'b0}}};
      chan_level[2] = {b, {FRAC{1'b0}}};
   endfunction

   function automatic void show_hue(logic [10:0] pos);
      logic [10:0] p;
      p = (pos > WHEEL_TOP) ? WHEEL_TOP : pos;
      if (p <= WHEEL_SEG1)      load_level(FULL_ON, p[7:0], 8'd0);
      else if (p <= WHEEL_SEG2) load_level(8'(WHEEL_SEG2 - p), FULL_ON, 8'd0);
      else if (p <= WHEEL_SEG3) load_level(8'd0, FULL_ON, 8'(p - WHEEL_SEG2));
      else if (p <= WHEEL_SEG4) load_level(8'd0, 8'(WHEEL_SEG4 - p), FULL_ON);
      else if (p <= WHEEL_SEG5) load_level(8'(p - WHEEL_SEG4), 8'd0, FULL_ON);
      else                      load_level(FULL_ON, 8'd0, 8'(WHEEL_TOP - p));
   endfunction

   // returns the colour shown before the request, then applies the request
   function automatic colour_t step_engine(led_cmd_t c);
      colour_t     shown;
      longint      goal;
      longint      lvl;
      longint      diff;
      logic [31:0] elapsed;
      shown.red   = chan_level[0][LEVEL_W-1:FRAC];
      shown.green = chan_level[1][LEVEL_W-1:FRAC];
      shown.blue  = chan_level[2][LEVEL_W-1:FRAC];
      shown.mode  = eng_mode;
      case (c.kind)
         OP_TICK: begin
            elapsed = c.time_ms - last_wheel_ms;
            if (reg_on) begin
               if (eng_mode == MODE_FADE && last_tick_ms != c.time_ms) begin
                  for (int i = 0; i < 3; i++) begin
                     goal = longint'(chan_goal[i]) << FRAC;
                     lvl  = longint'(chan_level[i]) + longint'(chan_step[i]);
                     if (lvl < 0) lvl = 0;
                     if (lvl > LEVEL_TOP) lvl = LEVEL_TOP;
                     if (((lvl > goal) ? lvl - goal : goal - lvl) < ONE_LEVEL) begin
                        lvl = goal;
                        chan_step[i] = '0;
                     end
                     chan_level[i] = lvl[LEVEL_W-1:0];
                  end
                  if (chan_step[0] == 0 && chan_step[1] == 0 && chan_step[2] == 0)
                     eng_mode = MODE_HOLD;
               end else if (eng_mode == MODE_WHEEL && elapsed > {16'd0, reg_interval}) begin
                  hue_pos = (hue_pos > WHEEL_TOP) ? 11'd0 : hue_pos + 11'd1;
                  show_hue(hue_pos);
                  last_wheel_ms = c.time_ms;
               end
            end
            last_tick_ms = c.time_ms;
         end
         OP_SET: begin
            load_level(c.red, c.green, c.blue);
            eng_mode = MODE_HOLD;
         end
         OP_FADE: begin
            chan_goal[0] = c.red;
            chan_goal[1] = c.green;
            chan_goal[2] = c.blue;
            for (int i = 0; i < 3; i++) begin
               if (c.fade_ticks == 0) begin
                  chan_level[i] = {chan_goal[i], {FRAC{1'b0}}};
                  chan_step[i]  = '0;
               end else begin
                  diff = (longint'(chan_goal[i]) << FRAC) - longint'(chan_level[i]);
                  diff = diff / longint'(c.fade_ticks);
                  chan_step[i] = diff[STEP_W-1:0];
               end
            end
            eng_mode = (c.fade_ticks == 0) ? MODE_HOLD : MODE_FADE;
         end
         default: eng_mode = MODE_WHEEL;
      endcase
      return shown;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 100)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   function automatic logic [7:0] rand_level();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic led_cmd_t make_cmd(op_type kind);
      led_cmd_t c;
      c.kind       = kind;
      c.time_ms    = $urandom;
      c.red        = rand_level();
      c.green      = rand_level();
      c.blue       = rand_level();
      c.fade_ticks = 16'($urandom_range(65535));
      return c;
   endfunction

   function automatic led_cmd_t tick_cmd(logic [31:0] t);
      led_cmd_t c;
      c = make_cmd(OP_TICK);
      c.time_ms = t;
      return c;
   endfunction

   function automatic logic [15:0] pick_period();
      case ($urandom_range(11))
         0:       return 16'd0;
         1:       return 16'hffff;
         2:       return 16'($urandom_range(65535));
         3:       return 16'($urandom_range(300, 13));
         default: return 16'($urandom_range(12, 1));
      endcase
   endfunction

   function automatic logic [31:0] wheel_gap();
      logic [31:0] iv;
      iv = {16'd0, reg_interval};
      case ($urandom_range(5))
         0:       return iv;
         1:       return 32'($urandom_range(iv));
         default: return iv + 32'd1 + 32'($urandom_range(2));
      endcase
   endfunction

   task automatic send(led_cmd_t c, bit typed = 1'b0, colour_t typed_colour = '0);
      colour_t predicted;
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.kind;
      req_tdata  <= {c.fade_ticks, c.blue, c.green, c.red, c.time_ms};
      do @(posedge clock); while (!req_tready);
      predicted = step_engine(c);
      expected_colours.push_back(typed ? typed_colour : predicted);
      req_beats++;
   endtask

   task automatic pause_until_empty();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_colours.size() != 0) @(posedge clock);
   endtask

   task automatic drain();
      pause_until_empty();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high so that writes can follow back to back
   task automatic csr_beat(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ENABLE:         reg_on = data[0];
         CSR_WHEEL_INTERVAL: reg_interval = data;
         default: ;
      endcase
   endtask

   task automatic run_scenarios(int count);
      int       stop_at;
      int       half_at;
      int       n;
      bit       paused;
      led_cmd_t c;
      stop_at = req_beats + count;
      half_at = req_beats + count / 2;
      paused  = 1'b0;
      while (req_beats < stop_at) begin
         if (!paused && req_beats >= half_at) begin
            pause_until_empty();
            paused = 1'b1;
         end
         n = $urandom_range(99);
         if (n < 35) begin
            c = make_cmd(OP_FADE);
            c.fade_ticks = pick_period();
            send(c);
            repeat ($urandom_range(16, 1)) begin
               clock_ms = clock_ms + 32'($urandom_range(3));
               send(tick_cmd(clock_ms));
            end
         end else if (n < 60) begin
            send(make_cmd(OP_WHEEL));
            repeat ($urandom_range(20, 1)) begin
               clock_ms = clock_ms + wheel_gap();
               send(tick_cmd(clock_ms));
            end
         end else if (n < 75) begin
            send(make_cmd(OP_SET));
            repeat ($urandom_range(3)) begin
               clock_ms = clock_ms + 32'($urandom_range(2));
               send(tick_cmd(clock_ms));
            end
         end else begin
            c = make_cmd(op_type'($urandom_range(3)));
            if (c.kind == OP_TICK) clock_ms = c.time_ms;
            send(c);
         end
      end
   endtask

   task automatic run_phase(bit on, logic [15:0] iv, int count, bit quiet);
      drain();
      csr_beat(CSR_ENABLE, {15'd0, on});
      csr_beat(CSR_WHEEL_INTERVAL, iv);
      csr_valid <= 1'b0;
      settings++;
      steady = quiet;
      run_scenarios(count);
      steady = 1'b0;
   endtask

   initial begin
      colour_t want;
      forever begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (expected_colours.size() == 0) begin
               mismatches++;
               if (mismatches <= 100)
                  $display("%0t: response beat with none pending, expected none, actual %h",
                           $time, rsp_tdata);
            end else begin
               want = expected_colours.pop_front();
               check_field("red", want.red, rsp_tdata[7:0]);
               check_field("green", want.green, rsp_tdata[15:8]);
               check_field("blue", want.blue, rsp_tdata[23:16]);
               check_field("mode", {6'd0, want.mode}, {6'd0, rsp_tdata[25:24]});
               rsp_beats++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < 3; i++) begin
         chan_level[i] = '0;
         chan_goal[i]  = '0;
         chan_step[i]  = '0;
      end
      eng_mode      = MODE_HOLD;
      hue_pos       = '0;
      last_tick_ms  = '0;
      last_wheel_ms = '0;
      reg_on        = ENABLE_RESET;
      reg_interval  = INTERVAL_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
      clock_ms = 32'd200;

      run_phase(1'b0, 16'd0,     20, 1'b0);
      run_phase(1'b1, 16'd0,     30, 1'b0);
      run_phase(1'b1, 16'hffff,  25, 1'b0);
      run_phase(1'b1, 16'($urandom_range(20, 1)), 40, 1'b1);
      run_phase(1'b0, 16'hffff,  10, 1'b0);
      run_phase(1'b1, INTERVAL_RESET, 25, 1'b0);

      // full lap of the wheel, one advance per tick
      drain();
      csr_beat(CSR_ENABLE, 16'd1);
      csr_beat(CSR_WHEEL_INTERVAL, 16'd0);
      csr_beat(CSR_SPARE, 16'hfffe);
      csr_valid <= 1'b0;
      settings++;
      send(make_cmd(OP_WHEEL));
      repeat (1540) begin
         clock_ms = clock_ms + 32'd1;
         send(tick_cmd(clock_ms));
      end
      drain();

      $display("Checked %0d response beats against %0d request beats under %0d settings,",
               rsp_beats, req_beats, settings);
      $display("with snap and timed fades, disabled ticks and a full hue wheel lap.");
      if (mismatches == 0 && expected_colours.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/rfhw_pkg.sv
hw/rtl/rfhw_front.sv
hw/rtl/rfhw_div.sv
hw/rtl/rfhw_engine.sv
hw/rtl/rgb_fade_and_hue_wheel_driver.sv
bench/tb_rgb_fade_and_hue_wheel_driver.sv
